FILE: rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types and constants shared by the request header parser modules.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    // byte constants
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_S     = 8'h53;

    localparam logic [15:0] MIN_LEN_RESET = 16'd18;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // byte classes
    localparam logic [3:0] CLS_METHOD  = 4'd0;
    localparam logic [3:0] CLS_RES     = 4'd1;
    localparam logic [3:0] CLS_QKEY    = 4'd2;
    localparam logic [3:0] CLS_QVAL    = 4'd3;
    localparam logic [3:0] CLS_DELIM   = 4'd4;
    localparam logic [3:0] CLS_HKEY    = 4'd5;
    localparam logic [3:0] CLS_HVAL    = 4'd6;
    localparam logic [3:0] CLS_AFTER   = 4'd7;
    localparam logic [3:0] CLS_IGNORED = 4'd8;

    // status codes
    localparam logic [3:0] ST_NONE         = 4'd0;
    localparam logic [3:0] ST_OK           = 4'd1;
    localparam logic [3:0] ST_TOO_SHORT    = 4'd2;
    localparam logic [3:0] ST_BAD_METHOD   = 4'd3;
    localparam logic [3:0] ST_EMPTY_RES    = 4'd4;
    localparam logic [3:0] ST_BAD_QKEY     = 4'd5;
    localparam logic [3:0] ST_BAD_QVAL     = 4'd6;
    localparam logic [3:0] ST_BAD_LINE_END = 4'd7;
    localparam logic [3:0] ST_BAD_HKEY     = 4'd8;
    localparam logic [3:0] ST_EMPTY_HKEY   = 4'd9;
    localparam logic [3:0] ST_MISSING_HVAL = 4'd10;
    localparam logic [3:0] ST_TRUNCATED    = 4'd11;

    // method codes
    localparam logic [1:0] MM_NONE = 2'd0;
    localparam logic [1:0] MM_GET  = 2'd1;
    localparam logic [1:0] MM_POST = 2'd2;

    typedef enum logic [3:0] {
        PH_METHOD,
        PH_RES,
        PH_QKEY,
        PH_QVAL,
        PH_TAIL,
        PH_TAIL_CR,
        PH_HSTART,
        PH_HSTART_CR,
        PH_HKEY,
        PH_HSPACE,
        PH_HVAL,
        PH_HVAL_CR,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_sp;
        logic       is_qmark;
        logic       is_cr;
        logic       is_lf;
        logic       is_eq;
        logic       is_amp;
        logic       is_colon;
        logic       is_g;
        logic       is_p;
        logic       last;
    } byte_item_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    // length of the method text including its space
    function automatic logic [2:0] method_len(input logic [1:0] mm);
        logic [2:0] n;
        n = (mm == MM_GET) ? 3'd4 : 3'd5;
        return n;
    endfunction

    // expected method byte at a position
    function automatic logic [7:0] method_byte(input logic [1:0] mm, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_SP;
        if (mm == MM_GET)
        begin
            unique case (idx)
                3'd0:    ch = CH_G;
                3'd1:    ch = CH_E;
                3'd2:    ch = CH_T;
                default: ch = CH_SP;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0:    ch = CH_P;
                3'd1:    ch = CH_O;
                3'd2:    ch = CH_S;
                3'd3:    ch = CH_T;
                default: ch = CH_SP;
            endcase
        end
        return ch;
    endfunction

endpackage

FILE: rtl/hrhp_front.sv
// ----------------------------------------------------------------------------
// hrhp_front
// Accepts request bytes and tags each with its character class flags.
// ----------------------------------------------------------------------------
module hrhp_front
    import hrhp_pkg::*;
(
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    byte_in,
    input  logic          last_byte,
    input  queue_status_t q_status,
    output logic          push,
    output byte_item_t    item
);

    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        item.data     = byte_in;
        item.is_sp    = (byte_in == CH_SP);
        item.is_qmark = (byte_in == CH_QMARK);
        item.is_cr    = (byte_in == CH_CR);
        item.is_lf    = (byte_in == CH_LF);
        item.is_eq    = (byte_in == CH_EQ);
        item.is_amp   = (byte_in == CH_AMP);
        item.is_colon = (byte_in == CH_COLON);
        item.is_g     = (byte_in == CH_G);
        item.is_p     = (byte_in == CH_P);
        item.last     = last_byte;
    end

endmodule

FILE: rtl/hrhp_queue.sv
// ----------------------------------------------------------------------------
// hrhp_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hrhp_queue
    import hrhp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  byte_item_t    item_in,
    input  logic          pop,
    output byte_item_t    item_out,
    output queue_status_t q_status
);

    byte_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    cnt_reg;
    logic [QPTR_W:0]    cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign item_out           = mem_reg[rd_ptr_reg];
    assign q_status.full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.not_empty = (cnt_reg != '0);

endmodule

FILE: rtl/hrhp_back.sv
// ----------------------------------------------------------------------------
// hrhp_back
// Per-byte parse state machine with a registered result stage.
// ----------------------------------------------------------------------------
module hrhp_back
    import hrhp_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  byte_item_t    item,
    output logic          pop,
    input  logic [15:0]   min_len,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [3:0]    byte_class,
    output logic          token_start,
    output logic [1:0]    method_code,
    output logic [3:0]    status,
    output logic [15:0]   header_end_offset,
    output logic          final_flag
);

    localparam int WIDE_W = OFFSET_BITS + 16;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic [1:0]             mm_reg;
    logic [1:0]             mm_next;
    logic [3:0]             err_reg;
    logic [3:0]             err_next;
    logic [OFFSET_BITS-1:0] eo_reg;
    logic [OFFSET_BITS-1:0] eo_next;
    logic                   tok_reg;
    logic                   tok_next;

    logic                   out_valid_reg;
    logic [3:0]             cls_reg;
    logic [3:0]             cls_next;
    logic                   start_reg;
    logic                   start_next;
    logic [1:0]             mcode_reg;
    logic [1:0]             mcode_next;
    logic [3:0]             status_reg;
    logic [3:0]             status_next;
    logic [15:0]            offset_reg;
    logic [15:0]            offset_next;
    logic                   final_reg;

    logic                   pos_zero;
    logic                   pos_ge_n;
    logic [2:0]             n_len;
    logic [WIDE_W-1:0]      len_wide;
    logic [WIDE_W-1:0]      min_wide;
    logic [WIDE_W-1:0]      eo_wide;

    assign pop = q_status.not_empty && (!out_valid_reg || out_ready);

    assign n_len    = method_len(mm_reg);
    assign pos_zero = (count_reg == '0);
    assign pos_ge_n = (count_reg[OFFSET_BITS-1:3] != '0) || (count_reg[2:0] >= n_len);

    // saturating byte count
    assign count_next = (&count_reg) ? count_reg : count_reg + 1'b1;

    assign len_wide = WIDE_W'(count_next);
    assign min_wide = WIDE_W'(min_len);
    assign eo_wide  = WIDE_W'(eo_next);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        mm_next    = mm_reg;
        err_next   = err_reg;
        tok_next   = tok_reg;
        eo_next    = eo_reg;
        unique case (phase_reg)
            PH_METHOD:
            begin
                if (pos_zero)
                begin
                    if (item.is_g)
                    begin
                        mm_next = MM_GET;
                    end
                    else if (item.is_p)
                    begin
                        mm_next = MM_POST;
                    end
                    else
                    begin
                        mm_next    = MM_NONE;
                        err_next   = ST_BAD_METHOD;
                        phase_next = PH_ERROR;
                    end
                end
                else if (mm_reg == MM_NONE || pos_ge_n
                         || item.data != method_byte(mm_reg, count_reg[2:0]))
                begin
                    mm_next    = MM_NONE;
                    err_next   = ST_BAD_METHOD;
                    phase_next = PH_ERROR;
                end
                else if (count_reg[2:0] == n_len - 3'd1)
                begin
                    phase_next = PH_RES;
                    tok_next   = 1'b0;
                end
            end
            PH_RES:
            begin
                if (item.is_sp || item.is_qmark)
                begin
                    if (!tok_reg)
                    begin
                        err_next   = ST_EMPTY_RES;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        phase_next = item.is_sp ? PH_TAIL : PH_QKEY;
                        tok_next   = 1'b0;
                    end
                end
                else
                begin
                    tok_next = 1'b1;
                end
            end
            PH_QKEY:
            begin
                if (item.is_eq)
                begin
                    phase_next = PH_QVAL;
                    tok_next   = 1'b0;
                end
                else if (item.is_cr || item.is_amp)
                begin
                    err_next   = ST_BAD_QKEY;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    tok_next = 1'b1;
                end
            end
            PH_QVAL:
            begin
                if (item.is_amp)
                begin
                    phase_next = PH_QKEY;
                    tok_next   = 1'b0;
                end
                else if (item.is_sp)
                begin
                    phase_next = PH_TAIL;
                end
                else if (item.is_cr || item.is_eq)
                begin
                    err_next   = ST_BAD_QVAL;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    tok_next = 1'b1;
                end
            end
            PH_TAIL:
            begin
                if (item.is_cr)
                begin
                    phase_next = PH_TAIL_CR;
                end
            end
            PH_TAIL_CR, PH_HVAL_CR:
            begin
                if (item.is_lf)
                begin
                    phase_next = PH_HSTART;
                end
                else
                begin
                    err_next   = ST_BAD_LINE_END;
                    phase_next = PH_ERROR;
                end
            end
            PH_HSTART:
            begin
                if (item.is_cr)
                begin
                    phase_next = PH_HSTART_CR;
                end
                else if (item.is_colon)
                begin
                    err_next   = ST_EMPTY_HKEY;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_HKEY;
                end
            end
            PH_HSTART_CR:
            begin
                if (item.is_lf)
                begin
                    phase_next = PH_DONE;
                    eo_next    = pos_zero ? '0 : count_reg - 1'b1;
                end
                else
                begin
                    err_next   = ST_BAD_HKEY;
                    phase_next = PH_ERROR;
                end
            end
            PH_HKEY:
            begin
                if (item.is_colon)
                begin
                    phase_next = PH_HSPACE;
                end
                else if (item.is_cr)
                begin
                    err_next   = ST_BAD_HKEY;
                    phase_next = PH_ERROR;
                end
            end
            PH_HSPACE:
            begin
                if (item.is_cr)
                begin
                    phase_next = PH_HVAL_CR;
                end
                else if (!item.is_sp)
                begin
                    phase_next = PH_HVAL;
                end
            end
            PH_HVAL:
            begin
                if (item.is_cr)
                begin
                    phase_next = PH_HVAL_CR;
                end
            end
            PH_DONE, PH_ERROR:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cls_next    = CLS_DELIM;
        start_next  = 1'b0;
        status_next = ST_NONE;
        offset_next = '0;
        unique case (phase_reg)
            PH_METHOD:
            begin
                cls_next   = CLS_METHOD;
                start_next = pos_zero;
            end
            PH_RES:
            begin
                if (!(item.is_sp || item.is_qmark))
                begin
                    cls_next   = CLS_RES;
                    start_next = !tok_reg;
                end
            end
            PH_QKEY:
            begin
                if (!(item.is_eq || item.is_cr || item.is_amp))
                begin
                    cls_next   = CLS_QKEY;
                    start_next = !tok_reg;
                end
            end
            PH_QVAL:
            begin
                if (!(item.is_amp || item.is_sp || item.is_cr || item.is_eq))
                begin
                    cls_next   = CLS_QVAL;
                    start_next = !tok_reg;
                end
            end
            PH_HSTART:
            begin
                if (!(item.is_cr || item.is_colon))
                begin
                    cls_next   = CLS_HKEY;
                    start_next = 1'b1;
                end
            end
            PH_HKEY:
            begin
                if (!(item.is_colon || item.is_cr))
                begin
                    cls_next = CLS_HKEY;
                end
            end
            PH_HSPACE:
            begin
                if (!(item.is_sp || item.is_cr))
                begin
                    cls_next   = CLS_HVAL;
                    start_next = 1'b1;
                end
            end
            PH_HVAL:
            begin
                if (!item.is_cr)
                begin
                    cls_next = CLS_HVAL;
                end
            end
            PH_DONE:
            begin
                cls_next = CLS_AFTER;
            end
            PH_ERROR:
            begin
                cls_next = CLS_IGNORED;
            end
            default:
            begin
                cls_next = CLS_DELIM;
            end
        endcase

        if (item.last)
        begin
            if (len_wide < min_wide)
            begin
                status_next = ST_TOO_SHORT;
            end
            else if (err_next != ST_NONE)
            begin
                status_next = err_next;
            end
            else
            begin
                unique case (phase_next)
                    PH_RES:
                    begin
                        status_next = ST_EMPTY_RES;
                    end
                    PH_QKEY:
                    begin
                        status_next = ST_BAD_QKEY;
                    end
                    PH_QVAL:
                    begin
                        status_next = ST_BAD_QVAL;
                    end
                    PH_HSTART:
                    begin
                        status_next = ST_OK;
                        offset_next = len_wide[15:0];
                    end
                    PH_HSTART_CR, PH_HKEY:
                    begin
                        status_next = ST_BAD_HKEY;
                    end
                    PH_HSPACE:
                    begin
                        status_next = ST_MISSING_HVAL;
                    end
                    PH_DONE:
                    begin
                        status_next = ST_OK;
                        offset_next = eo_wide[15:0];
                    end
                    default:
                    begin
                        status_next = ST_TRUNCATED;
                    end
                endcase
            end
        end
    end

    assign mcode_next = (phase_next != PH_METHOD) ? mm_next : MM_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD;
            count_reg     <= '0;
            mm_reg        <= MM_NONE;
            err_reg       <= ST_NONE;
            eo_reg        <= '0;
            tok_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (item.last)
                begin
                    phase_reg <= PH_METHOD;
                    count_reg <= '0;
                    mm_reg    <= MM_NONE;
                    err_reg   <= ST_NONE;
                    eo_reg    <= '0;
                    tok_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    count_reg <= count_next;
                    mm_reg    <= mm_next;
                    err_reg   <= err_next;
                    eo_reg    <= eo_next;
                    tok_reg   <= tok_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cls_reg    <= cls_next;
            start_reg  <= start_next;
            mcode_reg  <= mcode_next;
            status_reg <= status_next;
            offset_reg <= offset_next;
            final_reg  <= item.last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign byte_class        = cls_reg;
    assign token_start       = start_reg;
    assign method_code       = mcode_reg;
    assign status            = status_reg;
    assign header_end_offset = offset_reg;
    assign final_flag        = final_reg;

endmodule

FILE: rtl/http_request_header_parser_unit.sv
// an accepted byte is written into the byte queue, and its result is
//   registered in the output stage when the parse engine pops it
// throughput: one byte per cycle while out_ready is high, set by the parse
//   state update; in_ready drops only when the four-entry byte queue is full
// reset: asynchronous active low, clears the parse state, the queue and the
//   output valid flag, and sets min_len_reg to 18
// ----------------------------------------------------------------------------
// http_request_header_parser_unit
// Streams request bytes through a classifier, a byte queue and a parse engine.
// ----------------------------------------------------------------------------
module http_request_header_parser_unit
    import hrhp_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  byte_class,
    output logic        token_start,
    output logic [1:0]  method_code,
    output logic [3:0]  status,
    output logic [15:0] header_end_offset,
    output logic        final_flag
);

    logic [15:0]   min_len_reg;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    byte_item_t    front_item;
    byte_item_t    back_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            min_len_reg <= cfg_data;
        end
    end

    hrhp_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .last_byte (last_byte),
        .q_status  (q_status),
        .push      (push),
        .item      (front_item)
    );

    hrhp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (back_item),
        .q_status (q_status)
    );

    hrhp_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_status          (q_status),
        .item              (back_item),
        .pop               (pop),
        .min_len           (min_len_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .byte_class        (byte_class),
        .token_start       (token_start),
        .method_code       (method_code),
        .status            (status),
        .header_end_offset (header_end_offset),
        .final_flag        (final_flag)
    );

endmodule

FILE: rtl/hrhp_checker.sv
// ----------------------------------------------------------------------------
// hrhp_checker
// Port-level checks on the request header parser results.
// ----------------------------------------------------------------------------
module hrhp_checker
    import hrhp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  byte_class,
    input logic        token_start,
    input logic [3:0]  status,
    input logic [15:0] header_end_offset,
    input logic        final_flag
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_class)
        && $stable(status) && $stable(header_end_offset) && $stable(final_flag))
        else $error("stalled result changed");

    a_status_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_flag |-> status == ST_NONE)
        else $error("status on a non-final transaction");

    a_final_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_flag |-> status != ST_NONE)
        else $error("final transaction without status");

    a_offset_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> header_end_offset == 16'd0)
        else $error("offset without ok status");

    a_no_start_delim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_class == CLS_DELIM || byte_class == CLS_AFTER
        || byte_class == CLS_IGNORED) |-> !token_start)
        else $error("token start on a non-token class");

endmodule

bind http_request_header_parser_unit hrhp_checker u_hrhp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .byte_class        (byte_class),
    .token_start       (token_start),
    .status            (status),
    .header_end_offset (header_end_offset),
    .final_flag        (final_flag)
);

FILE: tb/http_request_header_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser_unit_tb
// Streams directed and random request text into the parser and compares the
// class, token start, method, status and header end offset of every byte
// against a cycle-free model of the parse, with random idling on both sides,
// a long receiver hold-off and several minimum lengths.
// ----------------------------------------------------------------------------
module http_request_header_parser_unit_tb;
    import hrhp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } req_byte_t;

    typedef struct packed {
        logic [3:0]  byte_class;
        logic        token_start;
        logic [1:0]  method_code;
        logic [3:0]  status;
        logic [15:0] header_end_offset;
        logic        final_flag;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  byte_class;
    logic        token_start;
    logic [1:0]  method_code;
    logic [3:0]  status;
    logic [15:0] header_end_offset;
    logic        final_flag;

    // model of the parse state
    phase_t      cur_phase = PH_METHOD;
    logic [15:0] byte_pos = '0;
    logic [1:0]  method_seen = MM_NONE;
    logic [3:0]  err_status = ST_NONE;
    logic [15:0] blank_line_at = '0;
    logic        token_open = 1'b0;
    logic [15:0] min_length = MIN_LEN_RESET;

    req_byte_t   pending_bytes[$];
    logic [7:0]  req_buf[$];
    verdict_t    verdict_q[$];
    req_byte_t   drive_item;
    verdict_t    head_verdict;
    int          bytes_queued = 0;
    int          fail_count = 0;
    logic        calm = 1'b0;
    logic        rx_hold = 1'b0;

    http_request_header_parser_unit i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .byte_in           (byte_in),
        .last_byte         (last_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .byte_class        (byte_class),
        .token_start       (token_start),
        .method_code       (method_code),
        .status            (status),
        .header_end_offset (header_end_offset),
        .final_flag        (final_flag)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void parse_error(input logic [3:0] code);
        err_status = code;
        cur_phase  = PH_ERROR;
    endfunction

    function automatic verdict_t classify_byte(input logic [7:0] b, input logic last);
        verdict_t    r;
        logic [15:0] pos;
        logic [39:0] text;
        logic [15:0] n;
        r = '0;
        r.byte_class = CLS_DELIM;
        pos = byte_pos;
        case (cur_phase)
            PH_METHOD:
            begin
                r.byte_class = CLS_METHOD;
                if (pos == 16'd0)
                begin
                    r.token_start = 1'b1;
                    if (b == CH_G)
                        method_seen = MM_GET;
                    else if (b == CH_P)
                        method_seen = MM_POST;
                    else
                    begin
                        method_seen = MM_NONE;
                        parse_error(ST_BAD_METHOD);
                    end
                end
                else
                begin
                    text = (method_seen == MM_GET) ? {"GET ", 8'h00} : "POST ";
                    n = (method_seen == MM_GET) ? 16'd4 : 16'd5;
                    if (method_seen == MM_NONE || pos >= n ||
                        b != text[39 - 8 * int'(pos[2:0]) -: 8])
                    begin
                        method_seen = MM_NONE;
                        parse_error(ST_BAD_METHOD);
                    end
                    else if (pos == n - 16'd1)
                    begin
                        cur_phase  = PH_RES;
                        token_open = 1'b0;
                    end
                end
            end
            PH_RES:
            begin
                if (b == CH_SP || b == CH_QMARK)
                begin
                    if (!token_open)
                        parse_error(ST_EMPTY_RES);
                    else
                    begin
                        cur_phase  = (b == CH_SP) ? PH_TAIL : PH_QKEY;
                        token_open = 1'b0;
                    end
                end
                else
                begin
                    r.byte_class  = CLS_RES;
                    r.token_start = !token_open;
                    token_open    = 1'b1;
                end
            end
            PH_QKEY:
            begin
                if (b == CH_EQ)
                begin
                    cur_phase  = PH_QVAL;
                    token_open = 1'b0;
                end
                else if (b == CH_CR || b == CH_AMP)
                    parse_error(ST_BAD_QKEY);
                else
                begin
                    r.byte_class  = CLS_QKEY;
                    r.token_start = !token_open;
                    token_open    = 1'b1;
                end
            end
            PH_QVAL:
            begin
                if (b == CH_AMP)
                begin
                    cur_phase  = PH_QKEY;
                    token_open = 1'b0;
                end
                else if (b == CH_SP)
                    cur_phase = PH_TAIL;
                else if (b == CH_CR || b == CH_EQ)
                    parse_error(ST_BAD_QVAL);
                else
                begin
                    r.byte_class  = CLS_QVAL;
                    r.token_start = !token_open;
                    token_open    = 1'b1;
                end
            end
            PH_TAIL:
            begin
                if (b == CH_CR)
                    cur_phase = PH_TAIL_CR;
            end
            PH_TAIL_CR, PH_HVAL_CR:
            begin
                if (b == CH_LF)
                    cur_phase = PH_HSTART;
                else
                    parse_error(ST_BAD_LINE_END);
            end
            PH_HSTART:
            begin
                if (b == CH_CR)
                    cur_phase = PH_HSTART_CR;
                else if (b == CH_COLON)
                    parse_error(ST_EMPTY_HKEY);
                else
                begin
                    cur_phase     = PH_HKEY;
                    r.byte_class  = CLS_HKEY;
                    r.token_start = 1'b1;
                end
            end
            PH_HSTART_CR:
            begin
                if (b == CH_LF)
                begin
                    cur_phase     = PH_DONE;
                    blank_line_at = (pos > 16'd0) ? pos - 16'd1 : 16'd0;
                end
                else
                    parse_error(ST_BAD_HKEY);
            end
            PH_HKEY:
            begin
                if (b == CH_COLON)
                    cur_phase = PH_HSPACE;
                else if (b == CH_CR)
                    parse_error(ST_BAD_HKEY);
                else
                    r.byte_class = CLS_HKEY;
            end
            PH_HSPACE:
            begin
                if (b == CH_CR)
                    cur_phase = PH_HVAL_CR;
                else if (b != CH_SP)
                begin
                    cur_phase     = PH_HVAL;
                    r.byte_class  = CLS_HVAL;
                    r.token_start = 1'b1;
                end
            end
            PH_HVAL:
            begin
                if (b == CH_CR)
                    cur_phase = PH_HVAL_CR;
                else
                    r.byte_class = CLS_HVAL;
            end
            PH_DONE:
                r.byte_class = CLS_AFTER;
            default:
                r.byte_class = CLS_IGNORED;
        endcase

        // length saturates at all ones
        if (byte_pos != '1)
            byte_pos = byte_pos + 16'd1;

        r.method_code = (cur_phase != PH_METHOD) ? method_seen : MM_NONE;
        r.final_flag  = last;

        if (last)
        begin
            if (byte_pos < min_length)
                r.status = ST_TOO_SHORT;
            else if (err_status != ST_NONE)
                r.status = err_status;
            else
            begin
                case (cur_phase)
                    PH_RES:
                        r.status = ST_EMPTY_RES;
                    PH_QKEY:
                        r.status = ST_BAD_QKEY;
                    PH_QVAL:
                        r.status = ST_BAD_QVAL;
                    PH_HSTART:
                    begin
                        r.status = ST_OK;
                        r.header_end_offset = byte_pos;
                    end
                    PH_HSTART_CR, PH_HKEY:
                        r.status = ST_BAD_HKEY;
                    PH_HSPACE:
                        r.status = ST_MISSING_HVAL;
                    PH_DONE:
                    begin
                        r.status = ST_OK;
                        r.header_end_offset = blank_line_at;
                    end
                    default:
                        r.status = ST_TRUNCATED;
                endcase
            end
            cur_phase     = PH_METHOD;
            byte_pos      = '0;
            method_seen   = MM_NONE;
            err_status    = ST_NONE;
            blank_line_at = '0;
            token_open    = 1'b0;
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            byte_in   <= '0;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                verdict_q.push_back(classify_byte(byte_in, last_byte));
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 10))
                begin
                    drive_item = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    byte_in   <= drive_item.data;
                    last_byte <= drive_item.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    head_verdict = verdict_q.pop_front();
                    check_field("byte_class", 32'(head_verdict.byte_class),
                                32'(byte_class));
                    check_field("token_start", 32'(head_verdict.token_start),
                                32'(token_start));
                    check_field("method_code", 32'(head_verdict.method_code),
                                32'(method_code));
                    check_field("status", 32'(head_verdict.status), 32'(status));
                    check_field("header_end_offset", 32'(head_verdict.header_end_offset),
                                32'(header_end_offset));
                    check_field("final_flag", 32'(head_verdict.final_flag),
                                32'(final_flag));
                end
            end
            out_ready <= !rx_hold && (calm || $urandom_range(99) >= 10);
        end
    end

    task add_bytes(input string s);
        for (int i = 0; i < s.len(); i++)
            req_buf.push_back(s[i]);
    endtask

    task flush_request();
        req_byte_t item;
        for (int i = 0; i < req_buf.size(); i++)
        begin
            item.data = req_buf[i];
            item.last = (i == req_buf.size() - 1);
            pending_bytes.push_back(item);
        end
        bytes_queued += req_buf.size();
        req_buf.delete();
    endtask

    task send_text(input string s);
        add_bytes(s);
        flush_request();
    endtask

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (c == CH_QMARK || c == CH_EQ || c == CH_AMP || c == CH_COLON)
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic logic [7:0] special_char();
        logic [7:0] c;
        case ($urandom_range(6))
            0:       c = CH_SP;
            1:       c = CH_QMARK;
            2:       c = CH_CR;
            3:       c = CH_LF;
            4:       c = CH_EQ;
            5:       c = CH_AMP;
            default: c = CH_COLON;
        endcase
        return c;
    endfunction

    task add_token(input int n);
        repeat (n) req_buf.push_back(token_char());
    endtask

    task build_random_request();
        int kind;
        int n;
        int cut;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            // noise
            n = $urandom_range(1, 12);
            repeat (n) req_buf.push_back(8'($urandom));
        end
        else
        begin
            add_bytes($urandom_range(1) ? "GET " : "POST ");
            if ($urandom_range(9) != 0)
                req_buf.push_back("/");
            add_token($urandom_range(0, 6));
            if ($urandom_range(1))
            begin
                req_buf.push_back(CH_QMARK);
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i != 0)
                        req_buf.push_back(CH_AMP);
                    add_token($urandom_range(1, 4));
                    req_buf.push_back(CH_EQ);
                    add_token($urandom_range(0, 4));
                end
            end
            add_bytes($urandom_range(1) ? " HTTP/1.1\r\n" : " \r\n");
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                add_token($urandom_range(1, 6));
                req_buf.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) req_buf.push_back(CH_SP);
                add_token($urandom_range(0, 8));
                add_bytes("\r\n");
            end
            if ($urandom_range(3) != 0)
            begin
                add_bytes("\r\n");
                add_token($urandom_range(0, 4));
            end
            // damage a few
            kind = $urandom_range(99);
            if (kind < 20)
                req_buf[$urandom_range(req_buf.size() - 1)] = special_char();
            else if (kind < 35)
            begin
                cut = $urandom_range(1, req_buf.size());
                while (req_buf.size() > cut)
                    void'(req_buf.pop_back());
            end
            else if (kind < 42)
                req_buf[$urandom_range(req_buf.size() - 1)] = 8'($urandom);
        end
        flush_request();
    endtask

    task run_random(input int goal);
        int first;
        first = bytes_queued;
        while (bytes_queued - first < goal)
            build_random_request();
    endtask

    task wait_drained();
        while (pending_bytes.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task set_min_length(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        min_length = v;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset minimum length
        send_text("GET /index.html HTTP/1.1\r\nHost: x\r\n\r\n");
        send_text("GET / \r\n\r\n");
        wait_drained();

        set_min_length(16'd0);
        send_text("X");
        send_text("G");
        send_text("GE");
        send_text("PUT");
        send_text("GETX12");
        send_text("GET  ");
        send_text("GET /");
        send_text("GET /?");
        send_text("GET /?a&");
        send_text("GET /?k=v&");
        send_text("GET /p?\r");
        send_text("GET /?a=");
        send_text("GET /?a=b=");
        send_text("GET / \rX");
        send_text("GET / \r");
        send_text("GET / \r\n:");
        send_text("GET / \r\nK");
        send_text("GET / \r\n\r");
        send_text("GET / \r\n\rX");
        send_text("GET / \r\nK:  ");
        send_text("GET / \r\nK: v");
        send_text("GET / \r\nK: v\r");
        send_text("GET / \r\nK:\r\n");
        send_text("POST /a?k=v&z= H\r\nA: b\r\n\r\nrest");
        wait_drained();

        set_min_length(16'($urandom_range(0, 40)));
        run_random(80);
        wait_drained();

        // receiver holds off while the sender keeps offering
        set_min_length(16'd0);
        run_random(80);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (100) @(posedge clk);
        rx_hold <= 1'b0;
        wait_drained();

        // no idling on either side
        calm <= 1'b1;
        set_min_length(16'd24);
        run_random(80);
        wait_drained();
        calm <= 1'b0;

        // largest minimum length
        set_min_length(16'hFFFF);
        send_text("GET / \r\n\r\n");
        wait_drained();

        set_min_length(MIN_LEN_RESET);
        send_text("POST /q?a=1 HTTP/1.1\r\nH: v\r\n");
        wait_drained();

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
